@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ design/mre_pkg.sv @@
// ----------------------------------------------------------------------------
// mre_pkg
// Types and constants shared by the root election front end, back end and top.
// ----------------------------------------------------------------------------
package mre_pkg;

	localparam logic [2:0] OP_TICK = 3'd0;
	localparam logic [2:0] OP_CAND = 3'd1;
	localparam logic [2:0] OP_HB   = 3'd2;
	localparam logic [2:0] OP_SURR = 3'd3;
	localparam logic [2:0] OP_DISC = 3'd4;
	localparam logic [2:0] OP_LOST = 3'd5;

	localparam logic [2:0] CFG_OWN_ID   = 3'd0;
	localparam logic [2:0] CFG_BASE     = 3'd1;
	localparam logic [2:0] CFG_CAP      = 3'd2;
	localparam logic [2:0] CFG_HB_INT   = 3'd3;
	localparam logic [2:0] CFG_HB_TMO   = 3'd4;
	localparam logic [2:0] CFG_CAND_INT = 3'd5;

	localparam logic [31:0] RST_OWN_ID   = 32'd1;
	localparam logic [15:0] RST_BASE     = 16'd500;
	localparam logic [15:0] RST_CAP      = 16'd100;
	localparam logic [31:0] RST_HB_INT   = 32'd10000;
	localparam logic [31:0] RST_HB_TMO   = 32'd35000;
	localparam logic [31:0] RST_CAND_INT = 32'd30000;

	localparam logic [15:0] ASSUMED_SCORE = 16'd500;
	localparam logic [31:0] MS_PER_HOUR   = 32'd3600000;
	// floor((2^32-1) / 3600000) = 1193 fits in 11 bits
	localparam int HOUR_BITS = 11;
	// 3600000 = 128 * 28125; ceil(2^40 / 28125), exact for 25-bit dividends
	localparam logic [25:0] HOUR_RECIP = 26'd39093747;

	typedef enum logic [2:0] {
		CL_TICK, CL_CAND, CL_HB, CL_SURR, CL_DISC, CL_LOST, CL_NONE
	} cls_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV, ST_DISPATCH, ST_LOCATE, ST_APPLY, ST_MOVE,
		ST_ELECT, ST_TICK_HB, ST_EMIT
	} state_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] now_ms;
		logic [31:0] node_id;
		logic [31:0] new_root_id;
		logic [15:0] score;
	} in_item_t;

	typedef struct packed {
		logic [31:0] root_id;
		logic        am_root;
		logic        root_changed;
		logic        cand_req;
		logic        hb_req;
		logic [31:0] heartbeat_number;
		logic [15:0] own_score;
		logic [4:0]  candidate_count;
	} out_item_t;

	typedef struct packed {
		cls_t        cls;
		logic [31:0] now_ms;
		logic [31:0] node_id;
		logic [31:0] new_root_id;
		logic [15:0] score;
	} q_entry_t;

endpackage

@@ design/mre_front.sv @@
// ----------------------------------------------------------------------------
// mre_front
// Accepts input transactions, classifies the operation and queues them in a
// two-entry FIFO for the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mre_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mre_pkg::in_item_t  in_item,
	output logic               q_valid,
	output mre_pkg::q_entry_t  q_entry,
	input  logic               q_pop
);

	mre_pkg::q_entry_t mem_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        fill_q;
	mre_pkg::q_entry_t new_entry;
	logic              push;

	always_comb begin
		new_entry.now_ms      = in_item.now_ms;
		new_entry.node_id     = in_item.node_id;
		new_entry.new_root_id = in_item.new_root_id;
		new_entry.score       = in_item.score;
		case (in_item.operation)
			mre_pkg::OP_TICK: new_entry.cls = mre_pkg::CL_TICK;
			mre_pkg::OP_CAND: new_entry.cls = mre_pkg::CL_CAND;
			mre_pkg::OP_HB:   new_entry.cls = mre_pkg::CL_HB;
			mre_pkg::OP_SURR: new_entry.cls = mre_pkg::CL_SURR;
			mre_pkg::OP_DISC: new_entry.cls = mre_pkg::CL_DISC;
			mre_pkg::OP_LOST: new_entry.cls = mre_pkg::CL_LOST;
			default:          new_entry.cls = mre_pkg::CL_NONE;
		endcase
	end

	assign in_ready = (fill_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (fill_q != 2'd0);
	assign q_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	`ASSERT_IMPL(a_fill_range, clk, arst_n, 1'b1, fill_q <= 2'd2)
	`ASSERT_IMPL(a_pop_nonempty, clk, arst_n, q_pop, fill_q != 2'd0)
	`ASSERT_NEXT(a_push_fills, clk, arst_n, push && !q_pop, fill_q != 2'd0)

endmodule

@@ design/mre_back.sv @@
// ----------------------------------------------------------------------------
// mre_back
// Sequencer that executes one queued event: own score by reciprocal multiply,
// table lookup, table update, election scan, heartbeat timing, result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mre_back #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               q_valid,
	input  mre_pkg::q_entry_t  q_entry,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output mre_pkg::out_item_t out_item
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int HB = mre_pkg::HOUR_BITS;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	// configuration
	logic [31:0] own_id_q, hb_int_q, hb_tmo_q, cand_int_q;
	logic [15:0] base_q, cap_q;

	// table
	logic [31:0] ids_q [DEPTH];
	logic [15:0] scores_q [DEPTH];
	logic [CW-1:0] cnt_q;

	// election state
	logic [31:0] root_q, hb_last_q, cand_last_q, seq_q;
	logic        flag_q;

	// per-item working registers
	mre_pkg::state_t   state_q, state_d;
	mre_pkg::q_entry_t item_q;
	logic [31:0] old_root_q, hb_num_q, best_id_q;
	logic [HB-1:0] hours_q;
	logic [CW-1:0] idx_q;
	logic [IW-1:0] k_q;
	logic        found_q, cand_tx_q, hb_tx_q;
	logic [15:0] best_sc_q;

	logic        out_valid_q;
	mre_pkg::out_item_t out_q;

	// combinational helpers
	logic [50:0]   hr_prod;
	logic [15:0]   own_sc;
	logic [16:0]   sc_sum;
	logic [15:0]   bonus;
	logic [31:0]   key;
	logic [31:0]   rd_id;
	logic [15:0]   rd_sc;
	logic          idx_live;
	logic          hit;
	logic          cand_due, tmo_due, hb_due;
	logic [15:0]   put_sc;
	logic          elect_last;
	logic          emit_go;
	logic          elect_better;
	logic          new_flag;

	// hours = (now >> 7) / 28125
	assign hr_prod = 51'(item_q.now_ms[31:7]) * 51'(mre_pkg::HOUR_RECIP);

	assign bonus  = ({5'd0, hours_q} > cap_q) ? cap_q : {5'd0, hours_q};
	assign sc_sum = {1'b0, base_q} + {1'b0, bonus};
	assign own_sc = sc_sum[16] ? 16'hFFFF : sc_sum[15:0];

	assign key      = (item_q.cls == mre_pkg::CL_SURR) ? item_q.new_root_id : item_q.node_id;
	assign rd_id    = ids_q[idx_q[IW-1:0]];
	assign rd_sc    = scores_q[idx_q[IW-1:0]];
	assign idx_live = (idx_q < cnt_q);
	assign hit      = idx_live && (rd_id == key);

	assign cand_due = ((item_q.now_ms - cand_last_q) >= cand_int_q);
	assign tmo_due  = (root_q != 32'd0) && !flag_q
		&& ((item_q.now_ms - hb_last_q) >= hb_tmo_q);
	assign hb_due   = flag_q && ((item_q.now_ms - hb_last_q) >= hb_int_q);

	assign put_sc     = (item_q.cls == mre_pkg::CL_CAND) ? item_q.score : mre_pkg::ASSUMED_SCORE;
	assign elect_last = !idx_live;
	assign elect_better = (rd_sc > best_sc_q) || ((rd_sc == best_sc_q) && (rd_id < best_id_q));
	assign new_flag   = (item_q.new_root_id == own_id_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mre_pkg::ST_IDLE: begin
				if (q_valid) state_d = mre_pkg::ST_DIV;
			end
			mre_pkg::ST_DIV: state_d = mre_pkg::ST_DISPATCH;
			mre_pkg::ST_DISPATCH: begin
				case (item_q.cls)
					mre_pkg::CL_TICK: state_d = tmo_due ? mre_pkg::ST_ELECT : mre_pkg::ST_TICK_HB;
					mre_pkg::CL_CAND: state_d = mre_pkg::ST_LOCATE;
					mre_pkg::CL_HB: state_d = (item_q.node_id == root_q) ?
						mre_pkg::ST_EMIT : mre_pkg::ST_LOCATE;
					mre_pkg::CL_SURR: state_d = (item_q.node_id == root_q) ?
						mre_pkg::ST_LOCATE : mre_pkg::ST_EMIT;
					mre_pkg::CL_LOST: state_d = mre_pkg::ST_LOCATE;
					default: state_d = mre_pkg::ST_EMIT;
				endcase
			end
			mre_pkg::ST_LOCATE: begin
				if (hit || !idx_live) state_d = mre_pkg::ST_APPLY;
			end
			mre_pkg::ST_APPLY: begin
				case (item_q.cls)
					mre_pkg::CL_HB: state_d = mre_pkg::ST_EMIT;
					mre_pkg::CL_LOST: begin
						if (found_q) state_d = mre_pkg::ST_MOVE;
						else if (item_q.node_id == root_q) state_d = mre_pkg::ST_ELECT;
						else state_d = mre_pkg::ST_EMIT;
					end
					default: state_d = mre_pkg::ST_ELECT;
				endcase
			end
			mre_pkg::ST_MOVE: begin
				state_d = (item_q.node_id == root_q) ? mre_pkg::ST_ELECT : mre_pkg::ST_EMIT;
			end
			mre_pkg::ST_ELECT: begin
				if (elect_last) begin
					state_d = (item_q.cls == mre_pkg::CL_TICK) ?
						mre_pkg::ST_TICK_HB : mre_pkg::ST_EMIT;
				end
			end
			mre_pkg::ST_TICK_HB: state_d = mre_pkg::ST_EMIT;
			mre_pkg::ST_EMIT: begin
				if (!out_valid_q || out_ready) state_d = mre_pkg::ST_IDLE;
			end
			default: state_d = mre_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		q_pop   = 1'b0;
		emit_go = 1'b0;
		case (state_q)
			mre_pkg::ST_IDLE: q_pop = q_valid;
			mre_pkg::ST_EMIT: emit_go = !out_valid_q || out_ready;
			default: begin
				q_pop   = 1'b0;
				emit_go = 1'b0;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// table storage: one write address per cycle
	always_ff @(posedge clk) begin
		if (state_q == mre_pkg::ST_APPLY && item_q.cls != mre_pkg::CL_LOST) begin
			if (found_q) begin
				scores_q[k_q] <= put_sc;
			end else if (cnt_q < DEPTH_C) begin
				ids_q[cnt_q[IW-1:0]]    <= key;
				scores_q[cnt_q[IW-1:0]] <= put_sc;
			end
		end
		if (state_q == mre_pkg::ST_MOVE) begin
			ids_q[k_q]    <= rd_id;
			scores_q[k_q] <= rd_sc;
		end
	end

	// per-item payload registers
	always_ff @(posedge clk) begin
		if (state_q == mre_pkg::ST_IDLE && q_valid) begin
			item_q <= q_pop ? q_entry : item_q;
			old_root_q <= root_q;
		end
		if (state_q == mre_pkg::ST_LOCATE && hit) begin
			k_q <= idx_q[IW-1:0];
		end
		if (state_d != state_q) begin
			case (state_d)
				mre_pkg::ST_ELECT: begin
					best_id_q <= own_id_q;
					best_sc_q <= own_sc;
				end
				default: ;
			endcase
		end else if (state_q == mre_pkg::ST_ELECT && !elect_last && elect_better) begin
			best_id_q <= rd_id;
			best_sc_q <= rd_sc;
		end
		if (emit_go) begin
			out_q.root_id          <= root_q;
			out_q.am_root          <= flag_q;
			out_q.root_changed     <= (root_q != old_root_q);
			out_q.cand_req         <= cand_tx_q;
			out_q.hb_req           <= hb_tx_q;
			out_q.heartbeat_number <= hb_num_q;
			out_q.own_score        <= own_sc;
			out_q.candidate_count  <= 5'(cnt_q);
		end
	end

	// control and election state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q    <= mre_pkg::RST_OWN_ID;
			base_q      <= mre_pkg::RST_BASE;
			cap_q       <= mre_pkg::RST_CAP;
			hb_int_q    <= mre_pkg::RST_HB_INT;
			hb_tmo_q    <= mre_pkg::RST_HB_TMO;
			cand_int_q  <= mre_pkg::RST_CAND_INT;
			state_q     <= mre_pkg::ST_IDLE;
			cnt_q       <= '0;
			root_q      <= '0;
			flag_q      <= 1'b0;
			hb_last_q   <= '0;
			cand_last_q <= '0;
			seq_q       <= '0;
			hours_q     <= '0;
			idx_q       <= '0;
			found_q     <= 1'b0;
			cand_tx_q   <= 1'b0;
			hb_tx_q     <= 1'b0;
			hb_num_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					mre_pkg::CFG_OWN_ID:   own_id_q   <= cfg_data;
					mre_pkg::CFG_BASE:     base_q     <= cfg_data[15:0];
					mre_pkg::CFG_CAP:      cap_q      <= cfg_data[15:0];
					mre_pkg::CFG_HB_INT:   hb_int_q   <= cfg_data;
					mre_pkg::CFG_HB_TMO:   hb_tmo_q   <= cfg_data;
					mre_pkg::CFG_CAND_INT: cand_int_q <= cfg_data;
					default: ;
				endcase
			end

			case (state_q)
				mre_pkg::ST_IDLE: begin
					if (q_valid) begin
						cand_tx_q <= 1'b0;
						hb_tx_q   <= 1'b0;
						hb_num_q  <= '0;
					end
				end
				mre_pkg::ST_DIV: hours_q <= hr_prod[40 +: HB];
				mre_pkg::ST_DISPATCH: begin
					case (item_q.cls)
						mre_pkg::CL_TICK: begin
							if (cand_due) begin
								cand_tx_q   <= 1'b1;
								cand_last_q <= item_q.now_ms;
							end
							if (tmo_due) root_q <= '0;
						end
						mre_pkg::CL_HB: begin
							if (item_q.node_id == root_q) hb_last_q <= item_q.now_ms;
						end
						mre_pkg::CL_DISC: cand_tx_q <= 1'b1;
						default: ;
					endcase
				end
				mre_pkg::ST_LOCATE: begin
					if (hit) found_q <= 1'b1;
					else if (idx_live) idx_q <= idx_q + 1'b1;
				end
				mre_pkg::ST_APPLY: begin
					if (item_q.cls != mre_pkg::CL_LOST && !found_q && cnt_q < DEPTH_C) begin
						cnt_q <= cnt_q + 1'b1;
					end
					case (item_q.cls)
						mre_pkg::CL_CAND: begin
							if (!flag_q && own_sc > item_q.score) cand_tx_q <= 1'b1;
						end
						mre_pkg::CL_HB: begin
							root_q    <= item_q.node_id;
							hb_last_q <= item_q.now_ms;
							flag_q    <= (item_q.node_id == own_id_q);
						end
						mre_pkg::CL_SURR: begin
							root_q <= item_q.new_root_id;
							flag_q <= new_flag;
							if (new_flag && !flag_q) seq_q <= '0;
						end
						mre_pkg::CL_LOST: begin
							if (found_q) cnt_q <= cnt_q - 1'b1;
							else if (item_q.node_id == root_q) root_q <= '0;
						end
						default: ;
					endcase
				end
				mre_pkg::ST_MOVE: begin
					if (item_q.node_id == root_q) root_q <= '0;
				end
				mre_pkg::ST_ELECT: begin
					if (!elect_last) begin
						idx_q <= idx_q + 1'b1;
					end else if (best_id_q != root_q) begin
						root_q    <= best_id_q;
						hb_last_q <= item_q.now_ms;
						flag_q    <= (best_id_q == own_id_q);
						if (best_id_q == own_id_q) seq_q <= '0;
					end
				end
				mre_pkg::ST_TICK_HB: begin
					if (hb_due) begin
						hb_tx_q   <= 1'b1;
						hb_num_q  <= seq_q;
						seq_q     <= seq_q + 32'd1;
						hb_last_q <= item_q.now_ms;
					end
				end
				default: ;
			endcase

			// index setup on entry to a scan
			if (state_d != state_q) begin
				case (state_d)
					mre_pkg::ST_LOCATE: begin
						idx_q   <= '0;
						found_q <= 1'b0;
					end
					mre_pkg::ST_ELECT: idx_q <= '0;
					mre_pkg::ST_MOVE:  idx_q <= cnt_q - 1'b1;
					default: ;
				endcase
			end

			if (emit_go) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	`ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= DEPTH_C)
	`ASSERT_IMPL(a_hb_needs_root, clk, arst_n, out_valid_q && out_q.hb_req,
		out_q.am_root)
	`ASSERT_IMPL(a_hb_num_zero, clk, arst_n, out_valid_q && !out_q.hb_req,
		out_q.heartbeat_number == 32'd0)
	`ASSERT_IMPL(a_pop_idle, clk, arst_n, q_pop, state_q == mre_pkg::ST_IDLE)

endmodule

@@ design/mesh_root_election.sv @@
// ----------------------------------------------------------------------------
// mesh_root_election
// Root election for a mesh node: candidate table, own score, heartbeat and
// candidacy timers, with a queued front end and a sequenced back end.
// ----------------------------------------------------------------------------
//   channel   handshake              payload
//   in        in_valid / in_ready    in_item  (mre_pkg::in_item_t)
//   out       out_valid / out_ready  out_item (mre_pkg::out_item_t)
//   cfg       cfg_we                 cfg_index, cfg_data
//
// An event passes through pop, uptime hours by reciprocal multiply, dispatch,
// then a lookup scan over the table, an apply step, an election scan over the
// table, one entry per cycle, and a result step. A tick without timeout skips
// the scans. A result waiting on out_ready holds the back end; the two-entry
// front FIFO keeps taking input meanwhile until it is full.
// Reset clears control state, timers and the table count; table entries are
// not cleared.
module mesh_root_election #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mre_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output mre_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	logic              q_valid;
	logic              q_pop;
	mre_pkg::q_entry_t q_entry;

	mre_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_entry  (q_entry),
		.q_pop    (q_pop)
	);

	mre_back #(
		.DEPTH (TABLE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

@@ test/mesh_root_election_chk.sv @@
// ----------------------------------------------------------------------------
// mesh_root_election_chk
// Watches the event, status and register ports of the root election block,
// tracks its election state on the side and compares every status transaction
// with the predicted one, in order.
// ----------------------------------------------------------------------------
module mesh_root_election_chk
	import mre_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_item_t    in_item,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_item_t   out_item,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          err_count,
	output int          pending,
	output int          checked,
	output int          hb_seen,
	output int          cand_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;

	logic [31:0] own_id, hb_period, hb_timeout, cand_period;
	logic [15:0] base_sc, bonus_cap;

	logic [31:0] tbl_id [DEPTH];
	logic [15:0] tbl_sc [DEPTH];
	int          tbl_cnt;
	logic [31:0] root;
	logic        is_root;
	logic [31:0] hb_last, cand_last, hb_seq;

	out_item_t expected_status[$];

	assign pending = expected_status.size();

	function automatic logic [15:0] score_at(logic [31:0] now);
		logic [31:0] hrs;
		logic [16:0] s;
		hrs = now / MS_PER_HOUR;
		if (hrs > {16'd0, bonus_cap})
			hrs = {16'd0, bonus_cap};
		s = {1'b0, base_sc} + hrs[16:0];
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	function automatic int find_id(logic [31:0] id);
		for (int i = 0; i < tbl_cnt; i++)
			if (tbl_id[i] == id)
				return i;
		return -1;
	endfunction

	function automatic void upsert(logic [31:0] id, logic [15:0] sc);
		int k;
		k = find_id(id);
		if (k < 0) begin
			// table full: drop the new id
			if (tbl_cnt >= DEPTH)
				return;
			k = tbl_cnt;
			tbl_cnt++;
			tbl_id[k] = id;
		end
		tbl_sc[k] = sc;
	endfunction

	function automatic void elect(logic [31:0] now);
		logic [31:0] best_id;
		logic [15:0] best_sc;
		best_id = own_id;
		best_sc = score_at(now);
		for (int i = 0; i < tbl_cnt; i++)
			if (tbl_sc[i] > best_sc || (tbl_sc[i] == best_sc && tbl_id[i] < best_id)) begin
				best_sc = tbl_sc[i];
				best_id = tbl_id[i];
			end
		if (best_id != root) begin
			root = best_id;
			hb_last = now;
			is_root = (best_id == own_id);
			if (is_root)
				hb_seq = '0;
		end
	endfunction

	function automatic out_item_t election_step(in_item_t it);
		out_item_t   r;
		logic [31:0] prev_root;
		logic        was;
		int          k;
		r = '0;
		prev_root = root;
		case (it.operation)
			OP_TICK: begin
				if (it.now_ms - cand_last >= cand_period) begin
					r.cand_req = 1'b1;
					cand_last = it.now_ms;
				end
				if (root != 0 && !is_root && it.now_ms - hb_last >= hb_timeout) begin
					root = '0;
					elect(it.now_ms);
				end
				if (is_root && it.now_ms - hb_last >= hb_period) begin
					r.hb_req = 1'b1;
					r.heartbeat_number = hb_seq;
					hb_seq++;
					hb_last = it.now_ms;
				end
			end
			OP_CAND: begin
				upsert(it.node_id, it.score);
				if (!is_root && score_at(it.now_ms) > it.score)
					r.cand_req = 1'b1;
				elect(it.now_ms);
			end
			OP_HB: begin
				if (it.node_id != root) begin
					upsert(it.node_id, ASSUMED_SCORE);
					root = it.node_id;
					is_root = (it.node_id == own_id);
				end
				hb_last = it.now_ms;
			end
			OP_SURR: begin
				if (it.node_id == root) begin
					was = is_root;
					upsert(it.new_root_id, ASSUMED_SCORE);
					root = it.new_root_id;
					is_root = (it.new_root_id == own_id);
					if (is_root && !was)
						hb_seq = '0;
					elect(it.now_ms);
				end
			end
			OP_DISC: r.cand_req = 1'b1;
			OP_LOST: begin
				k = find_id(it.node_id);
				if (k >= 0) begin
					tbl_cnt--;
					tbl_id[k] = tbl_id[tbl_cnt];
					tbl_sc[k] = tbl_sc[tbl_cnt];
				end
				if (it.node_id == root) begin
					root = '0;
					elect(it.now_ms);
				end
			end
			default: ;
		endcase
		r.root_id = root;
		r.am_root = is_root;
		r.root_changed = (root != prev_root);
		r.own_score = score_at(it.now_ms);
		r.candidate_count = tbl_cnt[4:0];
		return r;
	endfunction

	task automatic report(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
			err_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			own_id = RST_OWN_ID;
			base_sc = RST_BASE;
			bonus_cap = RST_CAP;
			hb_period = RST_HB_INT;
			hb_timeout = RST_HB_TMO;
			cand_period = RST_CAND_INT;
			tbl_cnt = 0;
			root = '0;
			is_root = 1'b0;
			hb_last = '0;
			cand_last = '0;
			hb_seq = '0;
			expected_status.delete();
			err_count = 0;
			checked = 0;
			hb_seen = 0;
			cand_seen = 0;
		end else begin
			// compare first so a same-edge event never matches its own status
			if (out_valid && out_ready) begin
				if (expected_status.size() == 0) begin
					$display("%0t ns: unexpected status transaction, got %h", $time, out_item);
					err_count++;
				end else begin
					e = expected_status.pop_front();
					report("root_id", e.root_id, out_item.root_id);
					report("am_root", e.am_root, out_item.am_root);
					report("root_changed", e.root_changed, out_item.root_changed);
					report("cand_req", e.cand_req, out_item.cand_req);
					report("hb_req", e.hb_req, out_item.hb_req);
					report("heartbeat_number", e.heartbeat_number, out_item.heartbeat_number);
					report("own_score", e.own_score, out_item.own_score);
					report("candidate_count", e.candidate_count, out_item.candidate_count);
					checked++;
					hb_seen += e.hb_req;
					cand_seen += e.cand_req;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_OWN_ID:   own_id = cfg_data;
					CFG_BASE:     base_sc = cfg_data[15:0];
					CFG_CAP:      bonus_cap = cfg_data[15:0];
					CFG_HB_INT:   hb_period = cfg_data;
					CFG_HB_TMO:   hb_timeout = cfg_data;
					CFG_CAND_INT: cand_period = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_status.push_back(election_step(in_item));
		end
	end
endmodule

@@ test/mesh_root_election_tb.sv @@
// ----------------------------------------------------------------------------
// mesh_root_election_tb
// Drives directed and random election events through the root election block
// under five register settings, with random gaps on both channels, and takes
// the verdict from the side checker.
// ----------------------------------------------------------------------------
module mesh_root_election_tb;
	import mre_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;
	localparam int PHASE_ITEMS = 226;
	localparam int SETTLE = 80;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_item;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	int          err_count, pending, checked, hb_seen, cand_seen;
	int          sent;
	int          stall_left;
	logic        quiet;
	logic [31:0] now;
	logic [31:0] own;
	logic [31:0] last_root_hint;

	mesh_root_election dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	mesh_root_election_chk chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.err_count(err_count), .pending(pending), .checked(checked),
		.hb_seen(hb_seen), .cand_seen(cand_seen)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#10ms;
		$display("Timeout with %0d status transactions outstanding", pending);
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		int r;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			r = $urandom_range(0, 99);
			if (quiet || r < 70) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				stall_left <= (r < 97) ? $urandom_range(0, 3) : $urandom_range(10, 120);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 20);
		return $urandom_range(50, 200);
	endfunction

	task automatic send_event(logic [2:0] op, logic [31:0] t, logic [31:0] nid,
			logic [31:0] newid, logic [15:0] sc);
		int gap;
		in_item_t it;
		gap = pick_gap();
		it.operation = op;
		it.now_ms = t;
		it.node_id = nid;
		it.new_root_id = newid;
		it.score = sc;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	// hold until every status is back, then let the block drain
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_regs(logic [31:0] id, logic [15:0] base, logic [15:0] cap,
			logic [31:0] hbi, logic [31:0] hbt, logic [31:0] cdi);
		logic [31:0] v [6];
		v = '{id, {16'd0, base}, {16'd0, cap}, hbi, hbt, cdi};
		own = id;
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= i[2:0];
			cfg_data <= v[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] pick_id();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return 32'd100 + $urandom_range(0, 23);
		if (r < 83)
			return own;
		if (r < 88)
			return last_root_hint;
		if (r < 92)
			return 32'd0;
		if (r < 96)
			return $urandom;
		return {$urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h7FFFFFFF};
	endfunction

	function automatic logic [31:0] advance();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return now + $urandom_range(0, 3000);
		if (r < 90)
			return now + $urandom_range(0, 40000);
		if (r < 97)
			return now + $urandom_range(0, 500000000);
		return $urandom;
	endfunction

	task automatic random_events(int n);
		int          r;
		logic [2:0]  op;
		logic [31:0] nid;
		logic [15:0] sc;
		for (int i = 0; i < n; i++) begin
			now = advance();
			r = $urandom_range(0, 99);
			nid = pick_id();
			sc = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(400, 700));
			if (r < 3) begin
				// noise: every field random
				send_event(3'($urandom), $urandom, $urandom, $urandom, 16'($urandom));
				continue;
			end
			if (r < 30)
				op = OP_TICK;
			else if (r < 55)
				op = OP_CAND;
			else if (r < 70)
				op = OP_HB;
			else if (r < 80)
				op = OP_SURR;
			else if (r < 85)
				op = OP_DISC;
			else if (r < 97)
				op = OP_LOST;
			else
				op = r[0] ? OP_SPARE_A : OP_SPARE_B;
			if ((op == OP_SURR || op == OP_LOST) && $urandom_range(0, 1))
				nid = last_root_hint;
			if (op == OP_HB)
				last_root_hint = nid;
			send_event(op, now, nid, pick_id(), sc);
			if (op == OP_SURR)
				last_root_hint = pick_id();
		end
	endtask

	initial begin
		sent = 0;
		quiet = 1'b0;
		now = '0;
		own = RST_OWN_ID;
		last_root_hint = 32'd100;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_regs(RST_OWN_ID, RST_BASE, RST_CAP, RST_HB_INT, RST_HB_TMO, RST_CAND_INT);
		// directed: every operation, field extremes, zero id, unused codes
		send_event(OP_TICK, 32'd0, 32'd0, 32'd0, 16'd0);
		send_event(OP_DISC, 32'd5, 32'd200, 32'd0, 16'd0);
		send_event(OP_TICK, 32'd30000, 32'd0, 32'd0, 16'd0);
		send_event(OP_CAND, 32'd30001, 32'd5, 32'd0, 16'hFFFF);
		send_event(OP_CAND, 32'd30002, 32'd6, 32'd0, 16'd0);
		send_event(OP_HB, 32'd30003, 32'd5, 32'd0, 16'd0);
		send_event(OP_HB, 32'd30004, 32'd7, 32'd0, 16'd0);
		send_event(OP_SURR, 32'd30005, 32'd9, 32'd11, 16'd0);
		send_event(OP_SURR, 32'd30006, 32'd7, 32'd1, 16'd0);
		send_event(OP_TICK, 32'd40006, 32'd0, 32'd0, 16'd0);
		send_event(OP_TICK, 32'd50007, 32'd0, 32'd0, 16'd0);
		send_event(OP_LOST, 32'd50008, 32'd5, 32'd0, 16'd0);
		send_event(OP_LOST, 32'd50009, 32'd12345, 32'd0, 16'd0);
		send_event(OP_CAND, 32'd50010, 32'd0, 32'd0, 16'hFFFF);
		send_event(OP_LOST, 32'd50011, 32'd0, 32'd0, 16'd0);
		send_event(OP_SPARE_A, 32'd50012, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
		send_event(OP_SPARE_B, 32'd50013, 32'd0, 32'd0, 16'd0);
		send_event(OP_CAND, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'd600);
		send_event(OP_TICK, 32'd100, 32'd0, 32'd0, 16'd0);
		send_event(OP_HB, 32'hFFFFFFFE, 32'd3, 32'd0, 16'd0);
		send_event(OP_TICK, 32'd200000, 32'd0, 32'd0, 16'd0);
		now = 32'd200000;
		random_events(PHASE_ITEMS - 21);
		settle();

		write_regs(32'd105, 16'd0, 16'd0, 32'd1, 32'd1, 32'd1);
		random_events(PHASE_ITEMS);
		settle();

		write_regs(32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		random_events(PHASE_ITEMS);
		settle();

		quiet = 1'b1;
		write_regs(32'd110, 16'd600, 16'd5, 32'd2000, 32'd7000, 32'd5000);
		random_events(PHASE_ITEMS);
		settle();
		quiet = 1'b0;

		// zero id and zero intervals: candidacy fires on every tick, heartbeat on every tick while root
		write_regs(32'd0, 16'd500, 16'd100, 32'd0, 32'd0, 32'd0);
		random_events(PHASE_ITEMS);
		settle();

		$display("Sent %0d events across five register settings; %0d statuses checked,",
			sent, checked);
		$display("  %0d with a heartbeat request and %0d with a candidacy request",
			hb_seen, cand_seen);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
